FILE: rtl/core/paa_pkg.sv
// shared types and constants for the priority aging arbiter
package paa_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int PRIO_W      = 16;
  localparam int BASE_W      = 5;
  localparam int IDX_FIELD_W = 4;
  localparam int ACT_W       = 5;
  localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(16);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_GRANT = 1'b1
  } op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                   ld_en;
    logic [IDX_FIELD_W-1:0] ld_idx;
    logic [BASE_W-1:0]      ld_lvl;
    logic                   age_en;
  } cell_cmd_t;

endpackage

FILE: rtl/core/paa_cell.sv
// one table entry of the arbiter row: priorities plus one scan stage
module paa_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  paa_pkg::cell_cmd_t        cmd,
  input  logic                      act,
  input  logic [IW-1:0]             upd_idx,
  input  logic                      tok_in,
  input  logic [paa_pkg::PRIO_W-1:0] cand_val_in,
  input  logic [IW-1:0]             cand_idx_in,
  output logic                      tok_out,
  output logic [paa_pkg::PRIO_W-1:0] cand_val_out,
  output logic [IW-1:0]             cand_idx_out
);
  import paa_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [BASE_W-1:0] base_r;
  logic [PRIO_W-1:0] cur_r;
  logic              tok_r;
  logic [PRIO_W-1:0] cval_r;
  logic [IW-1:0]     cidx_r;
  logic              ld_hit;
  logic              take;

  assign ld_hit = cmd.ld_en && (IDX == int'(cmd.ld_idx));
  // strict compare keeps the lowest index on a tie
  assign take   = act && (cur_r > cand_val_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      cur_r  <= '0;
    end else if (ld_hit) begin
      base_r <= cmd.ld_lvl;
      cur_r  <= PRIO_W'(cmd.ld_lvl);
    end else if (cmd.age_en && act) begin
      if (MY_IDX == upd_idx) begin
        cur_r <= PRIO_W'(base_r);
      end else if (cur_r != '1) begin
        cur_r <= cur_r + PRIO_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      if (take) begin
        cval_r <= cur_r;
        cidx_r <= MY_IDX;
      end else begin
        cval_r <= cand_val_in;
        cidx_r <= cand_idx_in;
      end
    end
  end

  assign tok_out      = tok_r;
  assign cand_val_out = cval_r;
  assign cand_idx_out = cidx_r;

endmodule

FILE: rtl/core/priority_aging_arbiter_top.sv
// top level of the priority aging arbiter: control, row of entry cells, ports
//
// channel | dir | handshake            | payload
// in      | in  | in_tvalid/in_tready  | tuser: operation; tdata: entry_index, base_level
// out     | out | out_tvalid/out_tready| tdata: winner_index, winner_priority
// cfg     | in  | cfg_valid/cfg_ready  | cfg_data: active_entries
//
// a load beat updates the addressed cell at the accept edge
// a grant beat: a token walks the cell row one cell per cycle carrying the best candidate,
//   then the winner register captures it and the final state ages the row
// one item is in flight at a time; in_tready is high only while idle
// a pending result sits in the output register, loads are still taken meanwhile
// synchronous active-low reset clears all priorities and sets active_entries to 16
module priority_aging_arbiter_top #(
  parameter int ENTRIES = paa_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [15:0]               in_tdata,   // [3:0] entry_index, [8:4] base_level
  input  logic                      in_tuser,   // [0] operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // [3:0] winner_index, [19:4] winner_priority
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [paa_pkg::ACT_W-1:0] cfg_data
);
  import paa_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [ACT_W-1:0]       active_r;
  logic [PRIO_W-1:0]      win_val_r;
  logic [IW-1:0]          win_idx_r;
  logic                   out_valid_r;
  logic [IDX_FIELD_W-1:0] out_idx_r;
  logic [PRIO_W-1:0]      out_prio_r;

  logic                   in_acc;
  logic                   scan_go;
  logic                   fin_go;
  cell_cmd_t              cmd;
  logic [ENTRIES-1:0]     act;

  // scan chain between cells, position 0 is the row input
  logic [ENTRIES:0]       tok;
  logic [PRIO_W-1:0]      cval [ENTRIES+1];
  logic [IW-1:0]          cidx [ENTRIES+1];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign scan_go   = in_acc && (op_t'(in_tuser) == OP_GRANT);
  // ageing waits until the output register can take the result
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    cmd.ld_en  = in_acc && (op_t'(in_tuser) == OP_LOAD);
    cmd.ld_idx = in_tdata[3:0];
    cmd.ld_lvl = in_tdata[8:4];
    cmd.age_en = fin_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_r <= cfg_data;
    end
  end

  // entry 0 always takes part, a count above the row saturates by itself
  for (genvar i = 0; i < ENTRIES; i++) begin : g_act
    assign act[i] = (i == 0) || (i < int'(active_r));
  end

  assign tok[0]  = scan_go;
  assign cval[0] = '0;
  assign cidx[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    paa_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .act          (act[i]),
      .upd_idx      (win_idx_r),
      .tok_in       (tok[i]),
      .cand_val_in  (cval[i]),
      .cand_idx_in  (cidx[i]),
      .tok_out      (tok[i+1]),
      .cand_val_out (cval[i+1]),
      .cand_idx_out (cidx[i+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (scan_go)      state_nxt = ST_SCAN;
      ST_SCAN: if (tok[ENTRIES]) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go)       state_nxt = ST_IDLE;
      default:                   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // winner at the end of the row
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && tok[ENTRIES]) begin
      win_val_r <= cval[ENTRIES];
      win_idx_r <= cidx[ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_idx_r  <= IDX_FIELD_W'(win_idx_r);
      out_prio_r <= win_val_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_prio_r, out_idx_r};

  // a new result only comes out of the final state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");

  // exactly one token on the row while scanning
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> $onehot(tok[ENTRIES:1]))
    else $error("scan token lost or duplicated");

  // the row is empty whenever the block is not scanning
  a_row_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (tok[ENTRIES:1] == '0))
    else $error("token on the row outside a scan");

endmodule
